// File: rtl/dct_pkg.sv
// Package with the item types, base codes and codon decode functions of the codon translator.
package dct_pkg;

    // ASCII codes of the DNA and mRNA bases.
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_U = 8'h55;

    // One-letter amino acid codes.
    localparam logic [7:0] AA_ALA = 8'h41; // A
    localparam logic [7:0] AA_CYS = 8'h43; // C
    localparam logic [7:0] AA_ASP = 8'h44; // D
    localparam logic [7:0] AA_GLU = 8'h45; // E
    localparam logic [7:0] AA_PHE = 8'h46; // F
    localparam logic [7:0] AA_GLY = 8'h47; // G
    localparam logic [7:0] AA_HIS = 8'h48; // H
    localparam logic [7:0] AA_ILE = 8'h49; // I
    localparam logic [7:0] AA_LYS = 8'h4B; // K
    localparam logic [7:0] AA_LEU = 8'h4C; // L
    localparam logic [7:0] AA_MET = 8'h4D; // M
    localparam logic [7:0] AA_ASN = 8'h4E; // N
    localparam logic [7:0] AA_PRO = 8'h50; // P
    localparam logic [7:0] AA_GLN = 8'h51; // Q
    localparam logic [7:0] AA_ARG = 8'h52; // R
    localparam logic [7:0] AA_SER = 8'h53; // S
    localparam logic [7:0] AA_THR = 8'h54; // T
    localparam logic [7:0] AA_VAL = 8'h56; // V
    localparam logic [7:0] AA_TRP = 8'h57; // W
    localparam logic [7:0] AA_TYR = 8'h59; // Y
    localparam logic [7:0] AA_BAD = 8'h5A; // Z, stop or unknown codon

    // Two-bit codes of the four mRNA bases, used to index the codon table.
    localparam logic [1:0] IDX_A = 2'd0;
    localparam logic [1:0] IDX_C = 2'd1;
    localparam logic [1:0] IDX_G = 2'd2;
    localparam logic [1:0] IDX_U = 2'd3;

    typedef struct packed {
        logic [7:0] base;
        logic       strand_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] amino_code;
        logic       bad_codon;
        logic [7:0] mrna_first;
        logic [7:0] mrna_second;
        logic [7:0] mrna_third;
        logic       last_codon;
    } t_out_item;

    // DNA base to its mRNA complement; other bytes pass through.
    function automatic logic [7:0] to_mrna(input logic [7:0] b);
        logic [7:0] m;
        case (b)
            CHAR_A:  m = CHAR_U;
            CHAR_C:  m = CHAR_G;
            CHAR_G:  m = CHAR_C;
            CHAR_T:  m = CHAR_A;
            default: m = b;
        endcase
        return m;
    endfunction

    // mRNA base to {known, index}.
    function automatic logic [2:0] base_index(input logic [7:0] b);
        logic [2:0] r;
        case (b)
            CHAR_A:  r = {1'b1, IDX_A};
            CHAR_C:  r = {1'b1, IDX_C};
            CHAR_G:  r = {1'b1, IDX_G};
            CHAR_U:  r = {1'b1, IDX_U};
            default: r = 3'b000;
        endcase
        return r;
    endfunction

    // Standard genetic code over the 64 codons; stop codons give the bad code.
    // Bit 0 of the third base's index is set for the pyrimidines C and U.
    function automatic logic [7:0] codon_amino(input logic [5:0] idx);
        logic [7:0] aa;
        logic [1:0] third;
        third = idx[1:0];
        case (idx[5:2])
            {IDX_U, IDX_U}: aa = third[0] ? AA_PHE : AA_LEU;
            {IDX_U, IDX_C}: aa = AA_SER;
            {IDX_U, IDX_A}: aa = third[0] ? AA_TYR : AA_BAD;
            {IDX_U, IDX_G}: begin
                case (third)
                    IDX_A:   aa = AA_BAD;
                    IDX_G:   aa = AA_TRP;
                    default: aa = AA_CYS;
                endcase
            end
            {IDX_C, IDX_U}: aa = AA_LEU;
            {IDX_C, IDX_C}: aa = AA_PRO;
            {IDX_C, IDX_A}: aa = third[0] ? AA_HIS : AA_GLN;
            {IDX_C, IDX_G}: aa = AA_ARG;
            {IDX_A, IDX_U}: aa = (third == IDX_G) ? AA_MET : AA_ILE;
            {IDX_A, IDX_C}: aa = AA_THR;
            {IDX_A, IDX_A}: aa = third[0] ? AA_ASN : AA_LYS;
            {IDX_A, IDX_G}: aa = third[0] ? AA_SER : AA_ARG;
            {IDX_G, IDX_U}: aa = AA_VAL;
            {IDX_G, IDX_C}: aa = AA_ALA;
            {IDX_G, IDX_A}: aa = third[0] ? AA_ASP : AA_GLU;
            {IDX_G, IDX_G}: aa = AA_GLY;
            default:        aa = AA_BAD;
        endcase
        return aa;
    endfunction

endpackage

// File: rtl/dna_codon_translator.sv
// Top level of the codon translator: base stream in, translated codons out.
// A codon's result passes through the codon register and then the output register.
// Throughput: one base item per cycle while o_in_stall is low; every completed codon yields one result item.
// Only the output handshake can stall the input, through the two registered stages.
// Reset is synchronous and active low; it clears the codon position and both
// valid flags, so the first base after reset starts a new codon.
module dna_codon_translator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dct_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dct_pkg::t_out_item  o_out_item
);

    logic               in_acc;
    logic               out_ready;
    logic               cod_valid;
    logic               cod_move;
    logic [7:0]         cod_first;
    logic [7:0]         cod_second;
    logic [7:0]         cod_third;
    logic               cod_last;
    dct_pkg::t_out_item lut_item;
    logic               r_out_valid;
    dct_pkg::t_out_item r_out_item;

    // The output register can take a new item when it is empty or being read.
    assign out_ready  = !r_out_valid || !i_out_stall;
    // A finished codon moves to the output register whenever there is room.
    assign cod_move   = cod_valid && out_ready;
    // The input only waits when a complete codon is stuck in the assembly stage.
    assign o_in_stall = cod_valid && !out_ready;
    assign in_acc     = i_in_valid && !o_in_stall;

    // First stage: complements each base, holds the first two, and registers
    // the complete codon when the third base arrives. Partial codons at the
    // strand end are dropped there.
    dct_assemble u_assemble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (in_acc),
        .i_item   (i_in_item),
        .i_drain  (cod_move),
        .o_valid  (cod_valid),
        .o_first  (cod_first),
        .o_second (cod_second),
        .o_third  (cod_third),
        .o_last   (cod_last)
    );

    // Second stage: table lookup between the codon register and the result register.
    dct_lookup u_lookup (
        .i_first  (cod_first),
        .i_second (cod_second),
        .i_third  (cod_third),
        .i_last   (cod_last),
        .o_item   (lut_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= cod_valid;
        end
        if (cod_move) begin
            r_out_item <= lut_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: rtl/dct_lookup.sv
// Codon table lookup that turns three mRNA bases into one result item.
module dct_lookup (
    input  logic [7:0]           i_first,
    input  logic [7:0]           i_second,
    input  logic [7:0]           i_third,
    input  logic                 i_last,
    output dct_pkg::t_out_item   o_item
);

    logic [2:0] idx_first;
    logic [2:0] idx_second;
    logic [2:0] idx_third;
    logic       all_known;
    logic [7:0] letter;

    assign idx_first  = dct_pkg::base_index(i_first);
    assign idx_second = dct_pkg::base_index(i_second);
    assign idx_third  = dct_pkg::base_index(i_third);
    assign all_known  = idx_first[2] & idx_second[2] & idx_third[2];

    // A codon with any byte outside the four bases is unknown.
    assign letter = all_known
        ? dct_pkg::codon_amino({idx_first[1:0], idx_second[1:0], idx_third[1:0]})
        : dct_pkg::AA_BAD;

    always_comb begin
        o_item.amino_code  = letter;
        o_item.bad_codon   = (letter == dct_pkg::AA_BAD);
        o_item.mrna_first  = i_first;
        o_item.mrna_second = i_second;
        o_item.mrna_third  = i_third;
        o_item.last_codon  = i_last;
    end

endmodule

// File: rtl/dct_codon_translator_top_placeholder.sv
// Codon assembly register stage of the codon translator.
module dct_assemble (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  dct_pkg::t_in_item   i_item,
    input  logic                i_drain,
    output logic                o_valid,
    output logic [7:0]          o_first,
    output logic [7:0]          o_second,
    output logic [7:0]          o_third,
    output logic                o_last
);

    logic [7:0] m;
    logic [1:0] r_pos;
    logic [7:0] r_held_first;
    logic [7:0] r_held_second;
    logic       r_valid;
    logic [7:0] r_first;
    logic [7:0] r_second;
    logic [7:0] r_third;
    logic       r_last;

    assign m = dct_pkg::to_mrna(i_item.base);

    // Position three cannot occur; it behaves like two through r_pos[1].
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (i_drain) begin
                r_valid <= 1'b0;
            end
            if (i_acc) begin
                if (r_pos[1]) begin
                    r_first  <= r_held_first;
                    r_second <= r_held_second;
                    r_third  <= m;
                    r_last   <= i_item.strand_end;
                    r_valid  <= 1'b1;
                    r_pos    <= 2'd0;
                end else if (r_pos[0]) begin
                    r_held_second <= m;
                    r_pos         <= i_item.strand_end ? 2'd0 : 2'd2;
                end else begin
                    r_held_first <= m;
                    r_pos        <= i_item.strand_end ? 2'd0 : 2'd1;
                end
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_first  = r_first;
    assign o_second = r_second;
    assign o_third  = r_third;
    assign o_last   = r_last;

endmodule

// File: sim/dna_codon_translator_tb.sv
// Self-checking testbench of the codon translator: base items in, checked codon items out.
module dna_codon_translator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Roughly how many base items the run offers, directed part included.
    localparam int ITEM_TARGET = 1850;
    // Cycles with no accepted item on either side before the run is declared hung.
    localparam int QUIET_LIMIT = 1000;
    // Length of the long receiver hold-off that fills the block up.
    localparam int LONG_HOLD = 300;
    // Settling time after the last expected result.
    localparam int TAIL_CYCLES = 8;

    // One entry of the sender's queue: either a base item, or a marker that makes
    // the sender pause until every expected codon has come out.
    typedef struct {
        bit                settle;
        dct_pkg::t_in_item item;
    } t_strand_slot;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    dct_pkg::t_in_item  in_item = '0;
    logic               out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    dct_pkg::t_out_item o_out_item;

    // Handshakes complete at a rising edge where valid is high and stall is low.
    wire in_fire = in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !out_stall;

    t_strand_slot       strand_queue[$];
    dct_pkg::t_out_item expected_codons[$];

    // Copy of the expected-codon count as it stood after the previous edge, so the
    // driver reads it without depending on the order of processes at an edge.
    int open_codons = 0;
    int mismatch_count = 0;
    int pushed_items = 0;
    int quiet_cycles = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int in_gap = 0;
    int out_wait = 0;
    bit sender_calm = 1'b0;
    bit receiver_calm = 1'b0;

    // Predictor state: the mRNA bases of the codon in progress and how many are held.
    logic [7:0] held_first = '0;
    logic [7:0] held_second = '0;
    int         codon_pos = 0;

    logic [7:0] dna_letters[4] = '{dct_pkg::CHAR_A, dct_pkg::CHAR_C, dct_pkg::CHAR_G,
                                   dct_pkg::CHAR_T};

    dna_codon_translator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // DNA base to its mRNA partner; any other byte is carried through as it is.
    function automatic logic [7:0] complement_base(input logic [7:0] b);
        case (b)
            dct_pkg::CHAR_A: return dct_pkg::CHAR_U;
            dct_pkg::CHAR_C: return dct_pkg::CHAR_G;
            dct_pkg::CHAR_G: return dct_pkg::CHAR_C;
            dct_pkg::CHAR_T: return dct_pkg::CHAR_A;
            default:         return b;
        endcase
    endfunction

    // Looks up a three-letter mRNA codon. Stop codons and anything holding a byte
    // other than A, C, G or U are missing from the table and give 'Z'.
    function automatic bit lookup_amino(input logic [23:0] codon, output logic [7:0] letter);
        bit found;
        found = 1'b1;
        case (codon)
            "GCA", "GCC", "GCG", "GCU":               letter = "A";
            "AGA", "AGG", "CGA", "CGC", "CGG", "CGU": letter = "R";
            "GAC", "GAU":                             letter = "D";
            "AAC", "AAU":                             letter = "N";
            "UGC", "UGU":                             letter = "C";
            "GAA", "GAG":                             letter = "E";
            "CAA", "CAG":                             letter = "Q";
            "GGA", "GGC", "GGG", "GGU":               letter = "G";
            "CAC", "CAU":                             letter = "H";
            "AUA", "AUC", "AUU":                      letter = "I";
            "UUA", "UUG", "CUA", "CUC", "CUG", "CUU": letter = "L";
            "AAA", "AAG":                             letter = "K";
            "AUG":                                    letter = "M";
            "UUC", "UUU":                             letter = "F";
            "CCA", "CCC", "CCG", "CCU":               letter = "P";
            "AGC", "AGU", "UCA", "UCC", "UCG", "UCU": letter = "S";
            "ACA", "ACC", "ACG", "ACU":               letter = "T";
            "UGG":                                    letter = "W";
            "UAC", "UAU":                             letter = "Y";
            "GUA", "GUC", "GUG", "GUU":               letter = "V";
            default: begin
                letter = "Z";
                found = 1'b0;
            end
        endcase
        return found;
    endfunction

    // Advances the predicted codon state by one accepted base item. A third base
    // yields one codon result; a strand end before that drops the partial codon.
    task automatic translate_base(input dct_pkg::t_in_item it, output bit made,
                                  output dct_pkg::t_out_item res);
        logic [7:0] m;
        logic [7:0] letter;
        bit         found;
        m = complement_base(it.base);
        made = 1'b0;
        res = '0;
        if (codon_pos == 0) begin
            held_first = m;
            codon_pos = it.strand_end ? 0 : 1;
        end else if (codon_pos == 1) begin
            held_second = m;
            codon_pos = it.strand_end ? 0 : 2;
        end else begin
            found = lookup_amino({held_first, held_second, m}, letter);
            res.amino_code = letter;
            res.bad_codon = !found;
            res.mrna_first = held_first;
            res.mrna_second = held_second;
            res.mrna_third = m;
            res.last_codon = it.strand_end;
            made = 1'b1;
            codon_pos = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Per-item wait of either side; calm stretches run with no idling at all.
    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 12));
    endfunction

    task automatic push_base(input logic [7:0] b, input bit close);
        t_strand_slot slot;
        slot.settle = 1'b0;
        slot.item.base = b;
        slot.item.strand_end = close;
        strand_queue.push_back(slot);
        pushed_items++;
    endtask

    task automatic push_text(input string dna, input bit close);
        for (int i = 0; i < dna.len(); i++) begin
            push_base(dna[i], close && (i == dna.len() - 1));
        end
    endtask

    task automatic push_settle();
        t_strand_slot slot;
        slot.settle = 1'b1;
        slot.item = '0;
        strand_queue.push_back(slot);
    endtask

    // Sender. A new item goes on the bus once the previous one is accepted and its
    // drawn gap has run out. A settle marker holds the bus idle until the block has
    // delivered every codon it owes.
    always @(posedge i_clk) begin
        t_strand_slot slot;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (strand_queue.size() == 0) begin
                in_valid <= 1'b0;
            end else if (strand_queue[0].settle) begin
                in_valid <= 1'b0;
                // The bus was already idle at the previous edge, so the count is complete.
                if (!in_valid && open_codons == 0) begin
                    strand_queue.delete(0);
                end
            end else begin
                slot = strand_queue.pop_front();
                in_item <= slot.item;
                in_valid <= 1'b1;
                if ($urandom_range(0, 49) == 0) begin
                    sender_calm = !sender_calm;
                end
                in_gap <= draw_wait(sender_calm);
            end
        end
    end

    // Receiver. After each accepted codon it stalls for a drawn number of cycles.
    // A long hold-off, asked for by the stimulus process, keeps the output stalled
    // while the sender goes on, so the block fills up and stalls its input.
    always @(posedge i_clk) begin
        int w;
        int h;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            out_wait <= 0;
            hold_left <= 0;
            holds_served <= 0;
        end else begin
            w = out_wait;
            if (out_fire) begin
                if ($urandom_range(0, 49) == 0) begin
                    receiver_calm = !receiver_calm;
                end
                w = draw_wait(receiver_calm);
            end else if (w > 0) begin
                w = w - 1;
            end
            h = hold_left;
            if (holds_served != hold_requests) begin
                h = LONG_HOLD;
                holds_served <= hold_requests;
            end else if (h > 0) begin
                h = h - 1;
            end
            out_wait <= w;
            hold_left <= h;
            out_stall <= (w > 0) || (h > 0);
        end
    end

    // Monitor. Accepted codons are compared field by field with the oldest
    // expectation; each accepted base item is run through the predictor.
    always @(posedge i_clk) begin
        dct_pkg::t_out_item want;
        dct_pkg::t_out_item got;
        bit                 made;
        if (!i_rst_n) begin
            codon_pos = 0;
            held_first = '0;
            held_second = '0;
            expected_codons.delete();
            open_codons <= 0;
        end else begin
            if (out_fire) begin
                got = o_out_item;
                if (expected_codons.size() == 0) begin
                    report_mismatch("codon item with none expected", got.amino_code, "-");
                end else begin
                    want = expected_codons.pop_front();
                    if (got.amino_code !== want.amino_code)
                        report_mismatch("amino_code", got.amino_code, want.amino_code);
                    if (got.bad_codon !== want.bad_codon)
                        report_mismatch("bad_codon", {7'b0, got.bad_codon},
                                        {7'b0, want.bad_codon});
                    if (got.mrna_first !== want.mrna_first)
                        report_mismatch("mrna_first", got.mrna_first, want.mrna_first);
                    if (got.mrna_second !== want.mrna_second)
                        report_mismatch("mrna_second", got.mrna_second, want.mrna_second);
                    if (got.mrna_third !== want.mrna_third)
                        report_mismatch("mrna_third", got.mrna_third, want.mrna_third);
                    if (got.last_codon !== want.last_codon)
                        report_mismatch("last_codon", {7'b0, got.last_codon},
                                        {7'b0, want.last_codon});
                end
            end
            if (in_fire) begin
                translate_base(in_item, made, want);
                if (made) begin
                    expected_codons.push_back(want);
                end
            end
            open_codons <= expected_codons.size();
        end
    end

    // Watchdog: a run that stops moving on both sides for too long has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int         strand_len;
        logic [7:0] b;
        bit         close;

        // Directed part. Start and tryptophan codons, the three stop codons, a codon
        // of bytes outside the alphabet at both extremes, a strand ending on a third
        // base, and strands ending after one and after two bases of a codon.
        push_text("TAC", 1'b0);
        push_text("ACC", 1'b0);
        push_text("ATT", 1'b0);
        push_text("ATC", 1'b0);
        push_text("ACT", 1'b0);
        push_base(8'h00, 1'b0);
        push_base(8'hFF, 1'b0);
        push_base(dct_pkg::CHAR_U, 1'b0);
        push_text("GGG", 1'b1);
        push_text("C", 1'b1);
        push_text("AT", 1'b1);
        push_settle();

        // Random part. Most strands are clean bases; about one base in sixteen is an
        // arbitrary byte. Lengths are mostly whole codons, sometimes ragged, and a
        // stray strand end now and then breaks a codon in the middle.
        while (pushed_items < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0) begin
                strand_len = $urandom_range(1, 40);
            end else begin
                strand_len = 3 * $urandom_range(1, 12);
            end
            for (int i = 0; i < strand_len; i++) begin
                if ($urandom_range(0, 15) == 0) begin
                    b = 8'($urandom_range(0, 255));
                end else begin
                    b = dna_letters[$urandom_range(0, 3)];
                end
                close = (i == strand_len - 1) || ($urandom_range(0, 199) == 0);
                push_base(b, close);
            end
            if ($urandom_range(0, 29) == 0) begin
                push_settle();
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Two long receiver hold-offs while the sender keeps offering items.
        while (strand_queue.size() > 1300) @(negedge i_clk);
        hold_requests++;
        while (strand_queue.size() > 600) @(negedge i_clk);
        hold_requests++;

        while (strand_queue.size() != 0 || in_valid || expected_codons.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
